// ===== src/trilinear_hex_shape_eval_core_macros.svh =====
// assertion helpers for the hexahedron shape evaluator
`ifndef TRILINEAR_HEX_SHAPE_EVAL_CORE_MACROS_SVH
`define TRILINEAR_HEX_SHAPE_EVAL_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define THSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thse assertion failed");
// next-cycle implication
`define THSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thse assertion failed");
`else
`define THSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define THSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/thse_pkg.sv =====
package thse_pkg;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 18;
  localparam int NODE_W    = 3;
  localparam int OUT_MAX   = 131071;
  localparam int OUT_MIN   = -131072;

  localparam logic [NODE_W-1:0] FIRST_NODE = 3'd0;
  localparam logic [NODE_W-1:0] LAST_NODE  = 3'd7;

  // queue status seen by the back end
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

// ===== src/thse_front.sv =====
module thse_front #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                start_i,
  input  logic signed [thse_pkg::IN_W-1:0]    xi_i,
  input  logic signed [thse_pkg::IN_W-1:0]    eta_i,
  input  logic signed [thse_pkg::IN_W-1:0]    zeta_i,
  input  logic                                last_point_i,
  input  thse_pkg::q_status_t                 q_stat_i,
  output logic                                busy_o,
  output logic                                push_o,
  output logic [6*(((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2):0] entry_o
);

  localparam int FW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
  localparam logic signed [FW-1:0] One = FW'(longint'(1) << FRAC_BITS);

  logic signed [FW-1:0] lo0, lo1, lo2, hi0, hi1, hi2;

  // factors one - c and one + c, exact at this width
  assign lo0 = One - FW'(xi_i);
  assign hi0 = One + FW'(xi_i);
  assign lo1 = One - FW'(eta_i);
  assign hi1 = One + FW'(eta_i);
  assign lo2 = One - FW'(zeta_i);
  assign hi2 = One + FW'(zeta_i);

  assign busy_o  = q_stat_i.full;
  assign push_o  = start_i && !q_stat_i.full;
  assign entry_o = {last_point_i, hi2, hi1, hi0, lo2, lo1, lo0};

endmodule

// ===== src/thse_queue.sv =====
module thse_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     data_o,
  output thse_pkg::q_status_t  stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != FullCnt);
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.full      = (cnt_q == FullCnt);

endmodule

// ===== src/thse_back.sv =====
module thse_back #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  thse_pkg::q_status_t                  q_stat_i,
  input  logic [6*(((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2):0] q_data_i,
  output logic                                 q_pop_o,
  output logic                                 result_valid_o,
  output logic [thse_pkg::NODE_W-1:0]          node_o,
  output logic signed [thse_pkg::OUT_W-1:0]    weight_o,
  output logic signed [thse_pkg::OUT_W-1:0]    grad_xi_o,
  output logic signed [thse_pkg::OUT_W-1:0]    grad_eta_o,
  output logic signed [thse_pkg::OUT_W-1:0]    grad_zeta_o,
  output logic                                 last_node_o,
  output logic                                 batch_end_o
);

  localparam int FW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
  localparam int EW = 6 * FW + 1;
  localparam int PW = 2 * FW;
  localparam int TW = PW - FRAC_BITS;
  localparam int MW = TW + FW;
  localparam int GW = PW + 1;
  localparam int SH = FRAC_BITS + 3;
  localparam int NW = thse_pkg::NODE_W;
  localparam int OW = thse_pkg::OUT_W;
  localparam logic signed [MW-1:0] SatMax = MW'(thse_pkg::OUT_MAX);
  localparam logic signed [MW-1:0] SatMin = MW'(thse_pkg::OUT_MIN);

  function automatic logic signed [OW-1:0] sat(input logic signed [MW-1:0] v);
    logic signed [OW-1:0] r;
    if (v > SatMax) begin
      r = OW'(SatMax);
    end else if (v < SatMin) begin
      r = OW'(SatMin);
    end else begin
      r = OW'(v);
    end
    return r;
  endfunction

  // corner sign pattern: bit 0 xi, bit 1 eta, bit 2 zeta
  function automatic logic [2:0] corner_pos(input logic [NW-1:0] n);
    return {n[2], n[1], n[1] ^ n[0]};
  endfunction

  // corner sequencer
  logic          active_q;
  logic [NW-1:0] node_q;
  logic [EW-1:0] data_q;
  logic          load;

  // stage 1: pair products
  logic                 v1_q, batch1_q;
  logic [NW-1:0]        node1_q;
  logic signed [FW-1:0] f2_1_q;
  logic signed [PW-1:0] p01_q, p12_q, p02_q;

  // stage 2: weight product, finished gradients
  logic                 v2_q, batch2_q;
  logic [NW-1:0]        node2_q;
  logic signed [MW-1:0] wprod_q;
  logic signed [OW-1:0] g0_2_q, g1_2_q, g2_2_q;

  // stage 3: output register
  logic                 v3_q, batch3_q;
  logic [NW-1:0]        node3_q;
  logic signed [OW-1:0] w3_q, g0_3_q, g1_3_q, g2_3_q;

  logic signed [FW-1:0] lo0, lo1, lo2, hi0, hi1, hi2, f0, f1, f2;
  logic [2:0]           pos0, pos1;
  logic signed [TW-1:0] t1;
  logic signed [GW-1:0] gn0, gn1, gn2;
  logic signed [GW-1:0] gs0, gs1, gs2;

  assign load    = q_stat_i.not_empty && (!active_q || node_q == thse_pkg::LAST_NODE);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      node_q   <= thse_pkg::FIRST_NODE;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        node_q   <= thse_pkg::FIRST_NODE;
      end else if (active_q) begin
        if (node_q == thse_pkg::LAST_NODE) begin
          active_q <= 1'b0;
        end
        node_q <= node_q + NW'(1);
      end
      v1_q <= active_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign lo0  = data_q[0*FW +: FW];
  assign lo1  = data_q[1*FW +: FW];
  assign lo2  = data_q[2*FW +: FW];
  assign hi0  = data_q[3*FW +: FW];
  assign hi1  = data_q[4*FW +: FW];
  assign hi2  = data_q[5*FW +: FW];
  assign pos0 = corner_pos(node_q);
  assign f0   = pos0[0] ? hi0 : lo0;
  assign f1   = pos0[1] ? hi1 : lo1;
  assign f2   = pos0[2] ? hi2 : lo2;

  assign pos1 = corner_pos(node1_q);
  assign t1   = TW'(p01_q >>> FRAC_BITS);
  // sign goes on before the shift
  assign gn0  = pos1[0] ? GW'(p12_q) : -GW'(p12_q);
  assign gn1  = pos1[1] ? GW'(p02_q) : -GW'(p02_q);
  assign gn2  = pos1[2] ? GW'(p01_q) : -GW'(p01_q);
  assign gs0  = gn0 >>> SH;
  assign gs1  = gn1 >>> SH;
  assign gs2  = gn2 >>> SH;

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= q_data_i;
    end
    node1_q  <= node_q;
    batch1_q <= data_q[EW-1] && (node_q == thse_pkg::LAST_NODE);
    f2_1_q   <= f2;
    p01_q    <= f0 * f1;
    p12_q    <= f1 * f2;
    p02_q    <= f0 * f2;

    node2_q  <= node1_q;
    batch2_q <= batch1_q;
    wprod_q  <= t1 * f2_1_q;
    g0_2_q   <= sat(MW'(gs0));
    g1_2_q   <= sat(MW'(gs1));
    g2_2_q   <= sat(MW'(gs2));

    node3_q  <= node2_q;
    batch3_q <= batch2_q;
    w3_q     <= sat(wprod_q >>> SH);
    g0_3_q   <= g0_2_q;
    g1_3_q   <= g1_2_q;
    g2_3_q   <= g2_2_q;
  end

  assign result_valid_o = v3_q;
  assign node_o         = node3_q;
  assign weight_o       = w3_q;
  assign grad_xi_o      = g0_3_q;
  assign grad_eta_o     = g1_3_q;
  assign grad_zeta_o    = g2_3_q;
  assign last_node_o    = v3_q && (node3_q == thse_pkg::LAST_NODE);
  assign batch_end_o    = v3_q && batch3_q;

endmodule

// ===== src/trilinear_hex_shape_eval_core.sv =====
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------------------
// point     | in        | start high, busy low     | xi_i, eta_i, zeta_i, last_point_i
// corner    | out       | result_valid_o, 1 cycle  | node_o, weight_o, grad_*_o, last_node_o,
//           |           |                        | batch_end_o
//
// each point gives eight corner items without gaps, node 0 first; one corner leaves per
// cycle, so the output port sets the point rate, and queued points run back to back;
// from idle, a taken point passes the queue, the sequencer and the corner pipeline before
// its first corner is strobed; busy rises only while the queue is full; the corner pipeline
// never stalls; reset is asynchronous, active low, and empties the queue and the pipeline

`include "trilinear_hex_shape_eval_core_macros.svh"

module trilinear_hex_shape_eval_core #(
  parameter int FRAC_BITS   = 14,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [thse_pkg::IN_W-1:0]     xi_i,
  input  logic signed [thse_pkg::IN_W-1:0]     eta_i,
  input  logic signed [thse_pkg::IN_W-1:0]     zeta_i,
  input  logic                                 last_point_i,
  output logic                                 result_valid_o,
  output logic [thse_pkg::NODE_W-1:0]          node_o,
  output logic signed [thse_pkg::OUT_W-1:0]    weight_o,
  output logic signed [thse_pkg::OUT_W-1:0]    grad_xi_o,
  output logic signed [thse_pkg::OUT_W-1:0]    grad_eta_o,
  output logic signed [thse_pkg::OUT_W-1:0]    grad_zeta_o,
  output logic                                 last_node_o,
  output logic                                 batch_end_o
);

  // factor width: holds one +- c for any coordinate at this fraction length
  localparam int FW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
  // queue entry: six factors plus the last-point mark
  localparam int EW = 6 * FW + 1;

  thse_pkg::q_status_t q_stat;
  logic                push;
  logic                pop;
  logic [EW-1:0]       entry;
  logic [EW-1:0]       q_data;

  // front: takes the point and forms the six corner factors
  thse_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .start_i      (start),
    .xi_i         (xi_i),
    .eta_i        (eta_i),
    .zeta_i       (zeta_i),
    .last_point_i (last_point_i),
    .q_stat_i     (q_stat),
    .busy_o       (busy),
    .push_o       (push),
    .entry_o      (entry)
  );

  // short queue decoupling the front from the corner pipeline
  thse_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry),
    .pop_i  (pop),
    .data_o (q_data),
    .stat_o (q_stat)
  );

  // back: walks the eight corners through the multiply pipeline
  thse_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .q_data_i       (q_data),
    .q_pop_o        (pop),
    .result_valid_o (result_valid_o),
    .node_o         (node_o),
    .weight_o       (weight_o),
    .grad_xi_o      (grad_xi_o),
    .grad_eta_o     (grad_eta_o),
    .grad_zeta_o    (grad_zeta_o),
    .last_node_o    (last_node_o),
    .batch_end_o    (batch_end_o)
  );

  // a point's corners come out without gaps
  `THSE_ASSERT_NEXT(a_run_unbroken, clk_i, rst_ni, result_valid_o && !last_node_o, result_valid_o)
  // and in order
  `THSE_ASSERT_NEXT(a_node_order, clk_i, rst_ni, result_valid_o && !last_node_o, node_o == $past(node_o) + 3'd1)
  // batch end only ever marks the closing corner
  `THSE_ASSERT_IMPL(a_batch_on_last, clk_i, rst_ni, batch_end_o, last_node_o && result_valid_o)
  // a taken point is held in the queue on the next cycle
  `THSE_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, start && !busy, q_stat.not_empty)

endmodule

// ===== tb/sv/trilinear_hex_shape_eval_core_tb.sv =====
module trilinear_hex_shape_eval_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                          IN_W      = thse_pkg::IN_W;
  localparam int                          OUT_W     = thse_pkg::OUT_W;
  localparam int                          NODE_W    = thse_pkg::NODE_W;
  localparam int                          OUT_MAX   = thse_pkg::OUT_MAX;
  localparam int                          OUT_MIN   = thse_pkg::OUT_MIN;
  localparam logic [thse_pkg::NODE_W-1:0] LAST_NODE = thse_pkg::LAST_NODE;

  // fixed-point format of the coordinates and of every corner value
  localparam int     FRAC_BITS = 14;
  localparam longint ONE_FIX   = longint'(1) << FRAC_BITS;

  // sender idle rates, in idle cycles per hundred, one per phase
  localparam int IDLE_PCT_LIGHT = 11;
  localparam int IDLE_PCT_HEAVY = 66;
  localparam int IDLE_PCT_NONE  = 0;

  // random points per phase, roughly 160 in all with the directed ones
  localparam int RAND_PTS_LIGHT = 48;
  localparam int RAND_PTS_HEAVY = 48;
  localparam int RAND_PTS_NONE  = 46;

  // from idle, the last corner is strobed within this drain window after its point is taken
  localparam int DRAIN_CYCLES = 20;
  // the slowest run ends far short of this limit
  localparam int CYCLE_LIMIT  = 100000;

  localparam logic signed [IN_W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [IN_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic signed [IN_W-1:0] COORD_POS = 16'sh4000;  // +1.0
  localparam logic signed [IN_W-1:0] COORD_NEG = 16'shc000;  // -1.0
  localparam logic signed [IN_W-1:0] COORD_ZERO = 16'sh0000;

  // one point waiting to be driven, with the idle rate to apply before it
  typedef struct {
    logic signed [IN_W-1:0] xi;
    logic signed [IN_W-1:0] eta;
    logic signed [IN_W-1:0] zeta;
    logic                   last_point;
    int                     idle_pct;
  } point_t;

  // one expected corner item
  typedef struct {
    logic [NODE_W-1:0]       node;
    logic signed [OUT_W-1:0] weight;
    logic signed [OUT_W-1:0] grad_xi;
    logic signed [OUT_W-1:0] grad_eta;
    logic signed [OUT_W-1:0] grad_zeta;
    logic                    last_node;
    logic                    batch_end;
  } corner_t;

  // dut signals, all inputs known from time zero
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    start        = 1'b0;
  logic                    busy;
  logic signed [IN_W-1:0]  xi_i         = '0;
  logic signed [IN_W-1:0]  eta_i        = '0;
  logic signed [IN_W-1:0]  zeta_i       = '0;
  logic                    last_point_i = 1'b0;
  logic                    result_valid_o;
  logic [NODE_W-1:0]       node_o;
  logic signed [OUT_W-1:0] weight_o;
  logic signed [OUT_W-1:0] grad_xi_o;
  logic signed [OUT_W-1:0] grad_eta_o;
  logic signed [OUT_W-1:0] grad_zeta_o;
  logic                    last_node_o;
  logic                    batch_end_o;

  point_t  point_q[$];   // points not yet driven
  corner_t corner_q[$];  // corners predicted but not yet seen
  int      mismatch_cnt = 0;
  int      cycle_cnt    = 0;

  trilinear_hex_shape_eval_core #(
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .xi_i           (xi_i),
    .eta_i          (eta_i),
    .zeta_i         (zeta_i),
    .last_point_i   (last_point_i),
    .result_valid_o (result_valid_o),
    .node_o         (node_o),
    .weight_o       (weight_o),
    .grad_xi_o      (grad_xi_o),
    .grad_eta_o     (grad_eta_o),
    .grad_zeta_o    (grad_zeta_o),
    .last_node_o    (last_node_o),
    .batch_end_o    (batch_end_o)
  );

  // clamp to the signed q3.14 output range
  function automatic logic signed [OUT_W-1:0] sat_q3_14(input longint v);
    if (v > longint'(OUT_MAX)) begin
      return OUT_W'(OUT_MAX);
    end else if (v < longint'(OUT_MIN)) begin
      return OUT_W'(OUT_MIN);
    end
    return OUT_W'(v);
  endfunction

  // trilinear weights and gradients of all eight corners of one point,
  // queued in corner order; >>> on longint floors like the hardware shift
  function automatic void eval_hex_corners(input logic signed [IN_W-1:0] xi,
                                           input logic signed [IN_W-1:0] eta,
                                           input logic signed [IN_W-1:0] zeta,
                                           input logic last_point);
    longint  coord[3];
    longint  fac[3];
    longint  grad[3];
    longint  partial;
    bit      upper[3];
    corner_t cr;
    coord[0] = longint'(xi);
    coord[1] = longint'(eta);
    coord[2] = longint'(zeta);
    for (int k = 0; k < 8; k++) begin
      // corners run round the bottom face, then round the top face
      upper[0] = ((k & 3) == 1) || ((k & 3) == 2);
      upper[1] = (k & 2) != 0;
      upper[2] = (k & 4) != 0;
      for (int d = 0; d < 3; d++) begin
        fac[d] = upper[d] ? ONE_FIX + coord[d] : ONE_FIX - coord[d];
      end
      // weight is truncated once after the first product, again at the end
      partial = (fac[0] * fac[1]) >>> FRAC_BITS;
      grad[0] = fac[1] * fac[2];
      grad[1] = fac[0] * fac[2];
      grad[2] = fac[0] * fac[1];
      for (int d = 0; d < 3; d++) begin
        // sign goes on before the shift, so negative gradients floor downwards
        if (!upper[d]) begin
          grad[d] = -grad[d];
        end
        grad[d] = grad[d] >>> (FRAC_BITS + 3);
      end
      cr.node      = NODE_W'(k);
      cr.weight    = sat_q3_14((partial * fac[2]) >>> (FRAC_BITS + 3));
      cr.grad_xi   = sat_q3_14(grad[0]);
      cr.grad_eta  = sat_q3_14(grad[1]);
      cr.grad_zeta = sat_q3_14(grad[2]);
      cr.last_node = (NODE_W'(k) == LAST_NODE);
      cr.batch_end = (NODE_W'(k) == LAST_NODE) && last_point;
      corner_q.push_back(cr);
    end
  endfunction

  task automatic report_mismatch(input string field, input int node,
                                 input longint got, input longint want);
    $display("mismatch at %0t: corner %0d %s got %0d expected %0d",
             $realtime, node, field, got, want);
    mismatch_cnt++;
  endtask

  task automatic add_point(input logic signed [IN_W-1:0] xi,
                           input logic signed [IN_W-1:0] eta,
                           input logic signed [IN_W-1:0] zeta,
                           input logic last_point, input int idle_pct);
    point_t p;
    p.xi         = xi;
    p.eta        = eta;
    p.zeta       = zeta;
    p.last_point = last_point;
    p.idle_pct   = idle_pct;
    point_q.push_back(p);
  endtask

  // mostly inside the reference cube, sometimes anywhere in the 16-bit range
  function automatic logic signed [IN_W-1:0] rand_coord();
    if ($urandom_range(9) < 7) begin
      return IN_W'(int'($urandom_range(2 * ONE_FIX)) - int'(ONE_FIX));
    end
    return IN_W'($urandom);
  endfunction

  // batches of points closed by the last-point flag, with some stray flags
  task automatic add_random_batches(input int count, input int idle_pct);
    int batch_len;
    int pos;
    logic flag;
    while (count > 0) begin
      batch_len = $urandom_range(6, 1);
      if (batch_len > count) begin
        batch_len = count;
      end
      for (pos = 0; pos < batch_len; pos++) begin
        flag = (pos == batch_len - 1) ? 1'b1 : ($urandom_range(9) == 0);
        add_point(rand_coord(), rand_coord(), rand_coord(), flag, idle_pct);
      end
      count -= batch_len;
    end
  endtask

  // free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver: a point is taken at an edge with start high and busy low;
  // start is held while busy, and is written at most once per edge
  always @(posedge clk_i) begin
    point_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        eval_hex_corners(xi_i, eta_i, zeta_i, last_point_i);
      end
      if (!(start && busy)) begin
        if (point_q.size() != 0 && $urandom_range(99) >= point_q[0].idle_pct) begin
          nxt = point_q.pop_front();
          xi_i         <= nxt.xi;
          eta_i        <= nxt.eta;
          zeta_i       <= nxt.zeta;
          last_point_i <= nxt.last_point;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed corner is checked against the oldest prediction
  always @(posedge clk_i) begin
    corner_t exp_c;
    if (rst_ni && result_valid_o) begin
      if (corner_q.size() == 0) begin
        report_mismatch("unexpected item", int'(node_o), 0, 0);
      end else begin
        exp_c = corner_q.pop_front();
        if (node_o !== exp_c.node)
          report_mismatch("node", int'(exp_c.node), node_o, exp_c.node);
        if (weight_o !== exp_c.weight)
          report_mismatch("weight", int'(exp_c.node), weight_o, exp_c.weight);
        if (grad_xi_o !== exp_c.grad_xi)
          report_mismatch("grad_xi", int'(exp_c.node), grad_xi_o, exp_c.grad_xi);
        if (grad_eta_o !== exp_c.grad_eta)
          report_mismatch("grad_eta", int'(exp_c.node), grad_eta_o, exp_c.grad_eta);
        if (grad_zeta_o !== exp_c.grad_zeta)
          report_mismatch("grad_zeta", int'(exp_c.node), grad_zeta_o, exp_c.grad_zeta);
        if (last_node_o !== exp_c.last_node)
          report_mismatch("last_node", int'(exp_c.node), last_node_o, exp_c.last_node);
        if (batch_end_o !== exp_c.batch_end)
          report_mismatch("batch_end", int'(exp_c.node), batch_end_o, exp_c.batch_end);
      end
    end
  end

  // watchdog against a hung pipeline
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // directed: the eight corners of the cube, last one closing a batch
    for (int k = 0; k < 8; k++) begin
      add_point((((k & 3) == 1) || ((k & 3) == 2)) ? COORD_POS : COORD_NEG,
                (k & 2) ? COORD_POS : COORD_NEG,
                (k & 4) ? COORD_POS : COORD_NEG,
                k == 7, IDLE_PCT_LIGHT);
    end
    // centre, and the extremes of the coordinate range, well outside the cube
    add_point(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b0, IDLE_PCT_LIGHT);
    add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, IDLE_PCT_LIGHT);
    add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, IDLE_PCT_LIGHT);
    add_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, IDLE_PCT_LIGHT);
    add_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, IDLE_PCT_LIGHT);
    add_point(COORD_MAX, COORD_ZERO, COORD_MIN, 1'b1, IDLE_PCT_LIGHT);
    // alternating bit patterns, negative factors and odd truncation
    add_point(16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, IDLE_PCT_LIGHT);
    add_point(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b1, IDLE_PCT_LIGHT);
    add_point(16'shffff, 16'sh0001, 16'sh7000, 1'b0, IDLE_PCT_LIGHT);
    add_point(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1, IDLE_PCT_LIGHT);

    // random phases: light sender idling, heavy idling, then back to back
    add_random_batches(RAND_PTS_LIGHT, IDLE_PCT_LIGHT);
    add_random_batches(RAND_PTS_HEAVY, IDLE_PCT_HEAVY);
    add_random_batches(RAND_PTS_NONE, IDLE_PCT_NONE);

    // reset once, released on a clock edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every point to be taken and every corner to arrive
    while (point_q.size() != 0 || start) @(posedge clk_i);
    while (corner_q.size() != 0) @(posedge clk_i);
    // let any stray corner show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
